@@ rtl/rwos_pkg.sv @@
// ----------------------------------------------------------------------------
// rwos_pkg
// Shared types, constants and tables for the reactive waypoint steering block.
// ----------------------------------------------------------------------------
package rwos_pkg;

  // field widths
  localparam int DistW   = 16;
  localparam int PosW    = 16;
  localparam int HdW     = 15;
  localparam int LinW    = 15;
  localparam int AngMaxW = 14;
  localparam int CmdW    = 15;
  localparam int ModeW   = 3;
  localparam int CfgAW   = 3;
  localparam int CfgDW   = 16;

  // cordic sizing
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int CordicMax        = 20;
  localparam int IdxW             = $clog2(CordicMax);
  localparam int ZW               = 28;
  localparam int DivBits          = 15;

  // turn-rate divide by pi: floor(2^41 / pi_q24), one correction step after
  localparam int DivSteps   = 3;
  localparam int RecipMul   = 41721;
  localparam int RecipShift = 41;

  // angle constants, radians in Q24
  localparam logic signed [ZW:0] PiQ24     = 29'sd52707179;
  localparam logic signed [ZW:0] TwoPiQ24  = 29'sd105414358;
  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;

  // scale factors
  localparam int MagGain  = 39797;
  localparam int Div10Mul = 52429;

  // distance and turn limits
  localparam int ArriveTol   = 38;
  localparam int SideNear    = 102;
  localparam int FrontNear   = 76;
  localparam int QuarterTurn = 6434;
  localparam int HalfTurn    = 12868;
  localparam int LinMin      = 41;

  // configuration register indexes
  localparam logic [CfgAW-1:0] CFG_GOAL_X  = 3'd0;
  localparam logic [CfgAW-1:0] CFG_GOAL_Y  = 3'd1;
  localparam logic [CfgAW-1:0] CFG_LIN_MAX = 3'd2;
  localparam logic [CfgAW-1:0] CFG_ANG_MAX = 3'd3;
  localparam logic [CfgAW-1:0] CFG_THR     = 3'd4;

  // mode codes
  localparam logic [ModeW-1:0] MODE_ARRIVED = 3'd0;
  localparam logic [ModeW-1:0] MODE_SEEK    = 3'd1;
  localparam logic [ModeW-1:0] MODE_DRIVE   = 3'd2;
  localparam logic [ModeW-1:0] MODE_TURN    = 3'd3;
  localparam logic [ModeW-1:0] MODE_FAULT   = 3'd4;
  localparam logic [ModeW-1:0] MODE_UNDEC   = 3'd5;

  // turn kinds
  localparam logic [1:0] TURN_LEFT  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_FLIP  = 2'd2;

  typedef enum logic [2:0] {
    CLS_FAULT, CLS_ARRIVE, CLS_AVOID, CLS_SEEK, CLS_UNDEC
  } cls_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_DISP, OP_CITER, OP_MUL, OP_SCALE,
    OP_DIV, OP_SEEKFIN, OP_OUT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
  } sts_t;

  // arctangent of 2^-i in Q24
  function automatic logic signed [ZW-1:0] atan_q24(input logic [IdxW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rwos_ctrl.sv @@
// ----------------------------------------------------------------------------
// rwos_ctrl
// Sequencer: steps the datapath through classify, avoid or seek, cordic
// iterations, scaling, division and result hand-off.
// ----------------------------------------------------------------------------
module rwos_ctrl #(
  parameter int CORDIC_STEPS = rwos_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rwos_pkg::sts_t sts,
  output rwos_pkg::cmd_t cmd
);
  import rwos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DISP, S_CORD, S_MUL, S_SCALE, S_DIV, S_SEEK, S_FIN
  } state_t;

  state_t          state;
  logic [IdxW-1:0] idx;
  logic            out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // command decode
  always_comb begin
    cmd.idx = idx;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_PREP:  cmd.op = OP_PREP;
      S_DISP:  cmd.op = OP_DISP;
      S_CORD:  cmd.op = OP_CITER;
      S_MUL:   cmd.op = OP_MUL;
      S_SCALE: cmd.op = OP_SCALE;
      S_DIV:   cmd.op = OP_DIV;
      S_SEEK:  cmd.op = OP_SEEKFIN;
      S_FIN:   cmd.op = out_free ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PREP;
        end
        S_PREP: state <= S_DISP;
        S_DISP: begin
          idx <= '0;
          state <= (sts.cls == CLS_SEEK) ? S_CORD : S_FIN;
        end
        S_CORD: begin
          idx <= idx + 1'b1;
          if (idx == IdxW'(CORDIC_STEPS - 1)) state <= S_MUL;
        end
        S_MUL: state <= S_SCALE;
        S_SCALE: begin
          idx   <= IdxW'(DivSteps - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          idx <= idx - 1'b1;
          if (idx == '0) state <= S_SEEK;
        end
        S_SEEK: state <= S_FIN;
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/rwos_dp.sv @@
// ----------------------------------------------------------------------------
// rwos_dp
// Datapath: configuration registers, steering state, avoidance decision,
// iterative cordic vectoring, gain multiplies and reciprocal turn-rate divide.
// ----------------------------------------------------------------------------
module rwos_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rwos_pkg::cmd_t                      cmd,
  output rwos_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [rwos_pkg::CfgAW-1:0]          cfg_addr,
  input  logic [rwos_pkg::CfgDW-1:0]          cfg_wdata,
  input  logic [rwos_pkg::DistW-1:0]          dist_left,
  input  logic [rwos_pkg::DistW-1:0]          dist_right,
  input  logic [rwos_pkg::DistW-1:0]          dist_front,
  input  logic [rwos_pkg::DistW-1:0]          dist_front_left,
  input  logic [rwos_pkg::DistW-1:0]          dist_front_right,
  input  logic signed [rwos_pkg::PosW-1:0]    pose_x,
  input  logic signed [rwos_pkg::PosW-1:0]    pose_y,
  input  logic signed [rwos_pkg::HdW-1:0]     heading,
  output logic [rwos_pkg::LinW-1:0]           lin_cmd,
  output logic signed [rwos_pkg::CmdW-1:0]    ang_cmd,
  output logic [rwos_pkg::ModeW-1:0]          mode,
  output logic                                arrived_event
);
  import rwos_pkg::*;

  // configuration
  logic signed [PosW-1:0] goal_x, goal_y;
  logic [LinW-1:0]        lin_max;
  logic [AngMaxW-1:0]     ang_max;
  logic [DistW-1:0]       thr;
  logic [12:0]            side;
  logic [30:0]            kgain;
  logic [15:0]            ang3;
  logic [31:0]            side_prod;
  logic [30:0]            kgain_calc;

  // latched request
  logic [DistW-1:0]       dl, dr, df, dfl, dfr;
  logic signed [PosW-1:0] px, py;
  logic signed [HdW-1:0]  hd;

  // steering state
  logic                   avoid_active, turn_active, seeking_goal;
  logic [1:0]             turn_kind;
  logic signed [15:0]     turn_start;

  // prep results
  logic signed [16:0]     dx, dy;
  cls_t                   cls;
  logic [LinW-1:0]        lin_av;

  // cordic, scaling and division
  logic signed [ZW-1:0]   cx, cy, cz;
  logic [57:0]            prod;
  logic                   err_neg;
  logic [25:0]            err_abs;
  logic [LinW-1:0]        lin_s;
  logic [40:0]            rem;
  logic [56:0]            qp;
  logic [40:0]            qdp;
  logic [DivBits-1:0]     q;

  // staged result
  logic [LinW-1:0]        res_lin;
  logic signed [CmdW-1:0] res_ang;
  logic [ModeW-1:0]       res_mode;
  logic                   res_ev;

  assign sts.cls = cls;

  // derived config values, computed at write time
  assign ang3       = {2'b00, cfg_wdata[AngMaxW-1:0]} + {1'b0, cfg_wdata[AngMaxW-1:0], 1'b0};
  assign side_prod  = ang3 * 16'(Div10Mul);
  assign kgain_calc = cfg_wdata[LinW-1:0] * 16'(MagGain);

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x  <= '0;
      goal_y  <= '0;
      lin_max <= 15'd4096;
      ang_max <= 14'd4096;
      thr     <= 16'd256;
      side    <= 13'd1228;
      kgain   <= 31'(4096 * MagGain);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GOAL_X:  goal_x <= cfg_wdata;
        CFG_GOAL_Y:  goal_y <= cfg_wdata;
        CFG_LIN_MAX: begin
          lin_max <= cfg_wdata[LinW-1:0];
          kgain   <= kgain_calc;
        end
        CFG_ANG_MAX: begin
          ang_max <= cfg_wdata[AngMaxW-1:0];
          side    <= side_prod[31:19];
        end
        CFG_THR:     thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classification of the latched request
  logic signed [16:0] dx_c, dy_c;
  logic               fault, arrive, any_lt, all_gt;
  logic [DistW-1:0]   mfront;
  logic [30:0]        lin_av_prod;

  always_comb begin
    dx_c   = 17'(goal_x) - 17'(px);
    dy_c   = 17'(goal_y) - 17'(py);
    fault  = (dl == '0) || (dr == '0) || (df == '0) || (dfl == '0) || (dfr == '0);
    arrive = (dx_c >= -17'sd38) && (dx_c <= 17'sd38) &&
             (dy_c >= -17'sd38) && (dy_c <= 17'sd38);
    any_lt = (dl < thr) || (dr < thr) || (df < thr) || (dfl < thr) || (dfr < thr);
    all_gt = (dl > thr) && (dr > thr) && (df > thr) && (dfl > thr) && (dfr > thr);
    mfront = df;
    if (dfl < mfront) mfront = dfl;
    if (dfr < mfront) mfront = dfr;
    lin_av_prod = mfront * lin_max;
  end

  // avoidance decision
  logic [12:0]            half;
  logic signed [CmdW-1:0] half_s, side_s;
  logic signed [16:0]     hd_d;
  logic [16:0]            hd_dabs;
  logic [16:0]            limit;
  logic [LinW-1:0]        av_lin;
  logic signed [CmdW-1:0] av_ang;
  logic [ModeW-1:0]       av_mode;
  logic [1:0]             kind_n;
  logic                   tact_n;
  logic signed [15:0]     start_n;

  always_comb begin
    half    = ang_max[AngMaxW-1:1];
    half_s  = CmdW'(half);
    side_s  = CmdW'(side);
    hd_d    = 17'(hd) - 17'(turn_start);
    hd_dabs = hd_d[16] ? 17'(-hd_d) : 17'(hd_d);
    limit   = (turn_kind == TURN_LEFT || turn_kind == TURN_RIGHT) ?
              17'(QuarterTurn) : 17'(HalfTurn);
    av_lin  = '0;
    av_ang  = '0;
    av_mode = MODE_TURN;
    kind_n  = turn_kind;
    tact_n  = turn_active;
    start_n = turn_start;
    if (!avoid_active) begin
      // entry: quarter turn away from the goal side
      kind_n  = (dx > 0 || (dx == 0 && dy == 0)) ? TURN_RIGHT : TURN_LEFT;
      start_n = 16'(hd);
      tact_n  = 1'b1;
      av_ang  = (kind_n == TURN_RIGHT) ? -half_s : half_s;
    end else if (turn_active) begin
      if (hd_dabs >= limit) begin
        tact_n = 1'b0;
      end else begin
        av_ang = (turn_kind == TURN_RIGHT) ? -half_s : half_s;
      end
    end else begin
      // drive forward with side steer, or flip when the front is near
      av_lin  = lin_av;
      av_mode = MODE_DRIVE;
      if (dl <= DistW'(SideNear) || dr <= DistW'(SideNear)) begin
        if (dl < dr) av_ang = -side_s;
        else if (dr < dl) av_ang = side_s;
      end
      if (df <= DistW'(FrontNear)) begin
        kind_n  = TURN_FLIP;
        start_n = 16'(hd);
        tact_n  = 1'b1;
        av_ang  = half_s;
        av_lin  = '0;
        av_mode = MODE_TURN;
      end
    end
  end

  // cordic step and initial rotation inputs, heading error and turn-rate clamp
  logic signed [ZW-1:0] xe, ye, xsh, ysh;
  logic signed [ZW:0]   err_c;
  logic signed [ZW:0]   hd_q24;
  logic [AngMaxW-1:0]   qc;
  logic signed [CmdW-1:0] ang_f;

  always_comb begin
    xe     = ZW'($signed({dx, 8'd0}));
    ye     = ZW'($signed({dy, 8'd0}));
    xsh    = cx >>> cmd.idx;
    ysh    = cy >>> cmd.idx;
    hd_q24 = (ZW+1)'($signed({hd, 12'd0}));
    err_c  = (ZW+1)'(cz) - hd_q24;
    if (err_c > PiQ24) err_c = err_c - TwoPiQ24;
    else if (err_c < -PiQ24) err_c = err_c + TwoPiQ24;
    if (err_c >= PiQ24 || err_c <= -PiQ24) err_c = '0;
    qc      = (q > DivBits'(ang_max)) ? ang_max : q[AngMaxW-1:0];
    ang_f   = err_neg ? -CmdW'(qc) : CmdW'(qc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avoid_active <= 1'b0;
      turn_active  <= 1'b0;
      seeking_goal <= 1'b0;
      turn_kind    <= TURN_LEFT;
      turn_start   <= '0;
      cls          <= CLS_UNDEC;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          dl  <= dist_left;
          dr  <= dist_right;
          df  <= dist_front;
          dfl <= dist_front_left;
          dfr <= dist_front_right;
          px  <= pose_x;
          py  <= pose_y;
          hd  <= heading;
        end
        OP_PREP: begin
          dx     <= dx_c;
          dy     <= dy_c;
          lin_av <= (lin_av_prod[30:8] > 23'(lin_max)) ? lin_max : lin_av_prod[LinW+7:8];
          if (fault) cls <= CLS_FAULT;
          else if (arrive) cls <= CLS_ARRIVE;
          else if (any_lt) cls <= CLS_AVOID;
          else if (all_gt) cls <= CLS_SEEK;
          else cls <= CLS_UNDEC;
        end
        OP_DISP: begin
          res_lin <= '0;
          res_ang <= '0;
          res_ev  <= 1'b0;
          case (cls)
            CLS_FAULT: res_mode <= MODE_FAULT;
            CLS_ARRIVE: begin
              res_mode     <= MODE_ARRIVED;
              res_ev       <= seeking_goal;
              seeking_goal <= 1'b0;
              avoid_active <= 1'b0;
            end
            CLS_AVOID: begin
              res_lin      <= av_lin;
              res_ang      <= av_ang;
              res_mode     <= av_mode;
              turn_kind    <= kind_n;
              turn_active  <= tact_n;
              turn_start   <= start_n;
              avoid_active <= 1'b1;
            end
            CLS_SEEK: begin
              res_mode     <= MODE_SEEK;
              seeking_goal <= 1'b1;
              avoid_active <= 1'b0;
              if (xe < 0) begin
                if (ye >= 0) begin
                  cx <= ye;
                  cy <= -xe;
                  cz <= HalfPiQ24;
                end else begin
                  cx <= -ye;
                  cy <= xe;
                  cz <= -HalfPiQ24;
                end
              end else begin
                cx <= xe;
                cy <= ye;
                cz <= '0;
              end
            end
            default: res_mode <= MODE_UNDEC;
          endcase
        end
        OP_CITER: begin
          if (cy >= 0) begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + atan_q24(cmd.idx);
          end else begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - atan_q24(cmd.idx);
          end
        end
        OP_MUL: begin
          prod    <= cx[ZW-2:0] * kgain;
          err_neg <= err_c[ZW];
          err_abs <= err_c[ZW] ? 26'(-err_c) : 26'(err_c);
        end
        OP_SCALE: begin
          lin_s <= (prod[57:32] > 26'(lin_max)) ? lin_max : prod[LinW+31:32];
          rem   <= {ang_max, 1'b0} * err_abs;
          q     <= '0;
        end
        OP_DIV: begin
          // reciprocal estimate of rem / pi, low by at most one, then corrected
          if (cmd.idx == IdxW'(DivSteps - 1)) begin
            qp <= rem * 16'(RecipMul);
          end else if (cmd.idx != '0) begin
            q   <= qp[RecipShift+DivBits-1:RecipShift];
            qdp <= qp[RecipShift+DivBits-1:RecipShift] * 26'(PiQ24);
          end else begin
            if (rem >= qdp + 41'(PiQ24)) q <= q + 1'b1;
          end
        end
        OP_SEEKFIN: begin
          if (lin_s < LinW'(LinMin)) begin
            res_lin <= '0;
            res_ang <= '0;
          end else begin
            res_lin <= lin_s;
            res_ang <= ang_f;
          end
        end
        OP_OUT: begin
          lin_cmd       <= res_lin;
          ang_cmd       <= res_ang;
          mode          <= res_mode;
          arrived_event <= res_ev;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/reactive_waypoint_obstacle_steering.sv @@
// ----------------------------------------------------------------------------
// reactive_waypoint_obstacle_steering
// Per-tick velocity command from five ranges and the robot pose: stop at the
// waypoint, avoid obstacles, or steer to the goal with cordic atan2/hypot.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    dist_*, pose_x, pose_y, heading
//  out       out_valid / out_stall  lin_cmd, ang_cmd, mode, arrived_event
//  cfg       cfg_we                 cfg_addr, cfg_wdata
//
//  goal seek runs the iterative cordic unit and then the three-step turn-rate
//  divide before its result is handed off; fault, arrival, undecided and
//  avoidance requests go from classification straight to hand-off.
//  one request is in work at a time; a finished result waits in the output
//  register while the next request is taken.
//  synchronous active-high reset restores the register defaults and clears
//  the steering state.
// ----------------------------------------------------------------------------
module reactive_waypoint_obstacle_steering #(
  parameter int CORDIC_STEPS = rwos_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rwos_pkg::CfgAW-1:0]        cfg_addr,
  input  logic [rwos_pkg::CfgDW-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rwos_pkg::DistW-1:0]        dist_left,
  input  logic [rwos_pkg::DistW-1:0]        dist_right,
  input  logic [rwos_pkg::DistW-1:0]        dist_front,
  input  logic [rwos_pkg::DistW-1:0]        dist_front_left,
  input  logic [rwos_pkg::DistW-1:0]        dist_front_right,
  input  logic signed [rwos_pkg::PosW-1:0]  pose_x,
  input  logic signed [rwos_pkg::PosW-1:0]  pose_y,
  input  logic signed [rwos_pkg::HdW-1:0]   heading,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rwos_pkg::LinW-1:0]         lin_cmd,
  output logic signed [rwos_pkg::CmdW-1:0]  ang_cmd,
  output logic [rwos_pkg::ModeW-1:0]        mode,
  output logic                              arrived_event
);
  import rwos_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rwos_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  rwos_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .dist_left        (dist_left),
    .dist_right       (dist_right),
    .dist_front       (dist_front),
    .dist_front_left  (dist_front_left),
    .dist_front_right (dist_front_right),
    .pose_x           (pose_x),
    .pose_y           (pose_y),
    .heading          (heading),
    .lin_cmd          (lin_cmd),
    .ang_cmd          (ang_cmd),
    .mode             (mode),
    .arrived_event    (arrived_event)
  );

`ifndef SYNTHESIS
  // a taken request blocks the next one: in_stall is high in the following cycle
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while one in work");

  // mode code stays in its defined range
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode <= MODE_UNDEC)
    else $error("undefined mode");

  // stop modes carry zero commands
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == MODE_ARRIVED || mode == MODE_FAULT || mode == MODE_UNDEC)
    |-> lin_cmd == '0 && ang_cmd == '0)
    else $error("nonzero command in stop mode");

  // arrival event only with arrived mode
  a_event_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived_event |-> mode == MODE_ARRIVED)
    else $error("arrival event outside arrived mode");
`endif

endmodule
